FILE: rtl/core/prx_pkg.sv
package prx_pkg;

	// Sizes
	localparam int OFFSET_BITS    = 48;
	localparam int MAX_MIN_RUN    = 63;
	localparam int RUN_CAPACITY   = 1024;
	localparam int RUN_BITS       = $clog2(RUN_CAPACITY);
	localparam int MIN_BITS       = 6;
	localparam int PREFIX_DEPTH   = MAX_MIN_RUN;
	localparam int PREFIX_ABITS   = $clog2(PREFIX_DEPTH);
	localparam int CHAR_BITS      = 7;

	// Printable character range
	localparam logic [7:0] CHAR_LO = 8'd32;
	localparam logic [7:0] CHAR_HI = 8'd126;

	// Longest run length that is still counted
	localparam logic [RUN_BITS-1:0] RUN_CAP = RUN_BITS'(RUN_CAPACITY - 1);

	// Configuration register indexes
	localparam logic [1:0] CFG_MIN_RUN     = 2'd0;
	localparam logic [1:0] CFG_ENCODING    = 2'd1;
	localparam logic [1:0] CFG_BASE_OFFSET = 2'd2;

	// Unit encodings; codes 6 and 7 fall back to 8-bit
	typedef enum logic [2:0] {
		ENC_7BIT = 3'd0,
		ENC_8BIT = 3'd1,
		ENC_16LE = 3'd2,
		ENC_16BE = 3'd3,
		ENC_32LE = 3'd4,
		ENC_32BE = 3'd5
	} enc_t;

	localparam logic [MIN_BITS-1:0] MIN_RUN_RESET = MIN_BITS'(4);

	// Result kinds
	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_END  = 1'b1;

	// Output sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_BURST,
		ST_CHAR,
		ST_TERM
	} emit_state_t;

	// What one accepted byte asks the output side to deliver
	typedef struct packed {
		logic                    burst;     // replay the stored prefix first
		logic [PREFIX_ABITS-1:0] burst_len; // prefix characters to replay
		logic                    chr;       // current character follows
		logic [CHAR_BITS-1:0]    ch;
		logic                    term;      // end marker closes the beat list
		logic [OFFSET_BITS-1:0]  start;     // run start after this byte
	} prx_job_t;

endpackage

FILE: rtl/core/prx_prefix_ram.sv
module prx_prefix_ram import prx_pkg::*; (
	input  logic                    clk,
	input  logic                    wr_en,
	input  logic [PREFIX_ABITS-1:0] wr_addr,
	input  logic [CHAR_BITS-1:0]    wr_data,
	input  logic [PREFIX_ABITS-1:0] rd_addr,
	output logic [CHAR_BITS-1:0]    rd_data
);

	logic [CHAR_BITS-1:0] mem [PREFIX_DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

FILE: rtl/core/prx_scan.sv
module prx_scan import prx_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	// configuration
	input  logic                    cfg_wr,
	input  logic [1:0]              cfg_index,
	input  logic [OFFSET_BITS-1:0]  cfg_data,
	// byte stream
	input  logic                    accept,
	input  logic [7:0]              byte_value,
	input  logic                    end_of_range,
	// prefix store write port
	output logic                    wr_en,
	output logic [PREFIX_ABITS-1:0] wr_addr,
	output logic [CHAR_BITS-1:0]    wr_data,
	// work for the output side
	output logic                    job_valid,
	output prx_job_t                job
);

	logic [MIN_BITS-1:0]    min_len_q;
	enc_t                   enc_q;
	logic [OFFSET_BITS-1:0] base_q;

	logic [23:0]            unit_bytes_q, unit_bytes_d;
	logic [1:0]             phase_q, phase_d;
	logic [OFFSET_BITS-1:0] count_q, count_d;
	logic [RUN_BITS-1:0]    run_len_q, run_len_d;
	logic [OFFSET_BITS-1:0] run_start_q, run_start_d;

	logic [2:0]             usize;
	logic                   complete;
	logic [31:0]            full;
	logic [7:0]             c;
	logic                   rest_zero;
	logic                   ok_unit;
	logic [MIN_BITS-1:0]    m;
	logic [RUN_BITS-1:0]    m_run;
	logic [RUN_BITS-1:0]    nl;
	logic [OFFSET_BITS-1:0] ustart;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_len_q <= MIN_RUN_RESET;
			enc_q     <= ENC_8BIT;
			base_q    <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				CFG_MIN_RUN:     min_len_q <= cfg_data[MIN_BITS-1:0];
				CFG_ENCODING:    enc_q     <= enc_t'(cfg_data[2:0]);
				CFG_BASE_OFFSET: base_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Unit size and completion
	always_comb begin
		unique case (enc_q)
			ENC_16LE, ENC_16BE: usize = 3'd2;
			ENC_32LE, ENC_32BE: usize = 3'd4;
			default:            usize = 3'd1;
		endcase
	end

	assign complete = ({1'b0, phase_q} + 3'd1) >= usize;
	assign full     = {unit_bytes_q, byte_value};

	// Decode the unit from the newest bytes
	always_comb begin
		unique case (enc_q)
			ENC_16LE: begin
				c         = full[15:8];
				rest_zero = (full[7:0] == 8'd0);
			end
			ENC_16BE: begin
				c         = full[7:0];
				rest_zero = (full[15:8] == 8'd0);
			end
			ENC_32LE: begin
				c         = full[31:24];
				rest_zero = (full[23:0] == 24'd0);
			end
			ENC_32BE: begin
				c         = full[7:0];
				rest_zero = (full[31:8] == 24'd0);
			end
			default: begin
				c         = byte_value;
				rest_zero = 1'b1;
			end
		endcase
	end

	assign ok_unit = rest_zero && (c >= CHAR_LO) && (c <= CHAR_HI);

	// Effective minimum: zero means one, capped at the prefix depth
	always_comb begin
		m = (min_len_q == '0) ? MIN_BITS'(1) : min_len_q;
		if (m > MIN_BITS'(MAX_MIN_RUN)) begin
			m = MIN_BITS'(MAX_MIN_RUN);
		end
	end

	assign m_run  = RUN_BITS'(m);
	assign nl     = run_len_q + RUN_BITS'(1);
	assign ustart = base_q + count_q - OFFSET_BITS'(usize - 3'd1);

	// Run tracking and job build
	always_comb begin
		unit_bytes_d  = unit_bytes_q;
		phase_d       = phase_q;
		count_d       = count_q;
		run_len_d     = run_len_q;
		run_start_d   = run_start_q;
		wr_en         = 1'b0;
		job           = '0;
		job.burst_len = PREFIX_ABITS'(m - MIN_BITS'(1));
		job.ch        = c[CHAR_BITS-1:0];
		if (accept) begin
			if (complete) begin
				if (ok_unit) begin
					if (run_len_q == '0) begin
						run_start_d = ustart;
					end
					if (run_len_q < RUN_CAP) begin
						if (nl < m_run) begin
							wr_en = 1'b1;
						end else if (nl == m_run) begin
							job.burst = (m != MIN_BITS'(1));
							job.chr   = 1'b1;
						end else begin
							job.chr = 1'b1;
						end
						run_len_d = nl;
					end
				end else begin
					if (run_len_q >= m_run) begin
						job.term = 1'b1;
					end
					run_len_d = '0;
				end
				phase_d = '0;
			end else begin
				phase_d = phase_q + 2'd1;
			end
			unit_bytes_d = full[23:0];
			count_d      = count_q + OFFSET_BITS'(1);
			// range end closes the run and drops a partial unit
			if (end_of_range) begin
				if (run_len_d >= m_run) begin
					job.term = 1'b1;
				end
				run_len_d = '0;
				phase_d   = '0;
				count_d   = '0;
			end
		end
		job.start = run_start_d;
	end

	assign job_valid = accept;
	assign wr_addr   = run_len_q[PREFIX_ABITS-1:0];
	assign wr_data   = c[CHAR_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_bytes_q <= '0;
			phase_q      <= '0;
			count_q      <= '0;
			run_len_q    <= '0;
			run_start_q  <= '0;
		end else begin
			unit_bytes_q <= unit_bytes_d;
			phase_q      <= phase_d;
			count_q      <= count_d;
			run_len_q    <= run_len_d;
			run_start_q  <= run_start_d;
		end
	end

endmodule

FILE: rtl/core/prx_emit.sv
module prx_emit import prx_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	// work from the scanner
	input  logic                    job_valid,
	input  prx_job_t                job,
	output logic                    busy,
	// prefix store read port
	output logic [PREFIX_ABITS-1:0] rd_addr,
	input  logic [CHAR_BITS-1:0]    rd_data,
	// result channel
	output logic                    result_valid,
	input  logic                    result_stall,
	output logic                    kind,
	output logic [CHAR_BITS-1:0]    character,
	output logic [OFFSET_BITS-1:0]  run_offset,
	output logic                    last
);

	emit_state_t             state_q, state_d;
	logic [PREFIX_ABITS-1:0] idx_q, idx_d;
	logic [PREFIX_ABITS-1:0] len_q;
	logic [CHAR_BITS-1:0]    ch_q;
	logic                    term_q;

	logic                    out_valid_q;
	logic                    kind_q;
	logic [CHAR_BITS-1:0]    char_q;
	logic [OFFSET_BITS-1:0]  start_q;
	logic                    last_q;

	logic                    slot_free;
	logic                    load;
	logic                    ld_kind;
	logic [CHAR_BITS-1:0]    ld_char;
	logic                    ld_last;

	assign slot_free = !out_valid_q || !result_stall;
	// new byte only when idle and the output register can take a beat now
	assign busy      = (state_q != ST_IDLE) || !slot_free;

	// Sequencer: next state and output register load
	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		load    = 1'b0;
		ld_kind = KIND_CHAR;
		ld_char = '0;
		ld_last = 1'b0;
		rd_addr = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (job_valid) begin
					priority if (job.burst) begin
						state_d = ST_BURST;
						idx_d   = '0;
					end else if (job.chr) begin
						load    = 1'b1;
						ld_char = job.ch;
						ld_last = !job.term;
						state_d = job.term ? ST_TERM : ST_IDLE;
					end else if (job.term) begin
						load    = 1'b1;
						ld_kind = KIND_END;
						ld_last = 1'b1;
					end else begin
						// byte with nothing to deliver
						state_d = ST_IDLE;
					end
				end
			end
			ST_BURST: begin
				rd_addr = idx_q;
				if (slot_free) begin
					load    = 1'b1;
					ld_char = rd_data;
					// fetch the next entry so the registered read has it ready in the next cycle
					rd_addr = idx_q + PREFIX_ABITS'(1);
					idx_d   = idx_q + PREFIX_ABITS'(1);
					if (idx_q == len_q - PREFIX_ABITS'(1)) begin
						state_d = ST_CHAR;
					end
				end
			end
			ST_CHAR: begin
				if (slot_free) begin
					load    = 1'b1;
					ld_char = ch_q;
					ld_last = !term_q;
					state_d = term_q ? ST_TERM : ST_IDLE;
				end
			end
			ST_TERM: begin
				if (slot_free) begin
					load    = 1'b1;
					ld_kind = KIND_END;
					ld_last = 1'b1;
					state_d = ST_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Job payload held for the later beats
	always_ff @(posedge clk) begin
		if (job_valid) begin
			len_q   <= job.burst_len;
			ch_q    <= job.ch;
			term_q  <= job.term;
			start_q <= job.start;
		end
		if (load) begin
			kind_q <= ld_kind;
			char_q <= ld_char;
			last_q <= ld_last;
		end
	end

	assign result_valid = out_valid_q;
	assign kind         = kind_q;
	assign character    = char_q;
	assign run_offset   = start_q;
	assign last         = last_q;

	// Checks
	a_job_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid |-> state_q == ST_IDLE)
		else $error("byte taken while sequencer busy");

	a_job_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid |-> slot_free)
		else $error("byte taken while a stalled beat is pending");

	a_burst_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_BURST |-> idx_q < len_q)
		else $error("prefix replay index past prefix length");

	a_char_after_burst: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CHAR |-> $past(state_q) == ST_BURST || $past(state_q) == ST_CHAR)
		else $error("held character state entered without prefix replay");

endmodule

FILE: rtl/core/printable_run_extractor_top.sv
// Printable run extractor: takes one byte per cycle while byte_stall is low, groups bytes
// into 1, 2 or 4 byte units by the encoding register and reports runs of printable units as
// character beats followed by an end beat, each tagged with the run's start offset. A byte
// giving a character and an end beat delivers the character beat, then the end beat. The
// byte that brings a run to the minimum length replays the held prefix from the prefix
// memory, one entry per cycle through its single read port while the result side does not
// stall, then delivers its own character (and an end beat when the range also ends there).
// Result stalls hold the input once the output register is full. No clearing pass is needed
// after reset.
module printable_run_extractor_top import prx_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration writes
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [1:0]             cfg_index,
	input  logic [OFFSET_BITS-1:0] cfg_data,
	// byte stream
	input  logic                   byte_valid,
	output logic                   byte_stall,
	input  logic [7:0]             byte_value,
	input  logic                   end_of_range,
	// results
	output logic                   result_valid,
	input  logic                   result_stall,
	output logic                   kind,
	output logic [CHAR_BITS-1:0]   character,
	output logic [OFFSET_BITS-1:0] run_offset,
	output logic                   last
);

	logic                    accept;
	logic                    busy;
	logic                    job_valid;
	prx_job_t                job;
	logic                    wr_en;
	logic [PREFIX_ABITS-1:0] wr_addr;
	logic [CHAR_BITS-1:0]    wr_data;
	logic [PREFIX_ABITS-1:0] rd_addr;
	logic [CHAR_BITS-1:0]    rd_data;

	assign cfg_ready  = 1'b1;
	assign byte_stall = busy;
	assign accept     = byte_valid && !busy;

	prx_scan u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.accept       (accept),
		.byte_value   (byte_value),
		.end_of_range (end_of_range),
		.wr_en        (wr_en),
		.wr_addr      (wr_addr),
		.wr_data      (wr_data),
		.job_valid    (job_valid),
		.job          (job)
	);

	prx_prefix_ram u_prefix (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	prx_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_valid    (job_valid),
		.job          (job),
		.busy         (busy),
		.rd_addr      (rd_addr),
		.rd_data      (rd_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.kind         (kind),
		.character    (character),
		.run_offset   (run_offset),
		.last         (last)
	);

endmodule
